// ===== design/bmptr_pkg.sv =====
`default_nettype none

package bmptr_pkg;

  localparam int PixW      = 8;
  localparam int PageW     = 4;
  localparam int ColAddrW  = 8;
  localparam int CfgDataW  = 7;
  localparam int CfgIdxW   = 2;
  localparam int RowsPerStrip = 8;
  localparam int MaxPage   = 7;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH_BYTES  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_START_PAGE   = 2'd2,
    REG_START_COLUMN = 2'd3
  } cfg_reg_e;

  // One strip-closing transaction on its way to the column serializer.
  typedef struct packed {
    logic [PixW-1:0]     pix;
    logic [2:0]          rin;
    logic [PageW-1:0]    page;
    logic                perr;
    logic [ColAddrW-1:0] base;
    logic                first;
    logic                img_end;
  } strip_item_t;

  typedef logic [RowsPerStrip-1:0][PixW-1:0] col_bytes_t;

endpackage

`default_nettype wire

// ===== design/bmptr_pix_if.sv =====
`default_nettype none

interface bmptr_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bmptr_pkg::PixW-1:0]  pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

`default_nettype wire

// ===== design/bmptr_col_if.sv =====
`default_nettype none

interface bmptr_col_if;
  logic                            valid;
  logic                            ready;
  logic [bmptr_pkg::PixW-1:0]      column_byte;
  logic [bmptr_pkg::PageW-1:0]     page_addr;
  logic [bmptr_pkg::ColAddrW-1:0]  column_addr;
  logic                            page_begin;
  logic                            run_last;
  logic                            image_last;
  logic                            page_error;

  modport source (
    output valid, output column_byte, output page_addr, output column_addr,
    output page_begin, output run_last, output image_last, output page_error,
    input  ready
  );
  modport sink (
    input  valid, input column_byte, input page_addr, input column_addr,
    input  page_begin, input run_last, input image_last, input page_error,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/bitmap_to_page_column_transposer_core.sv =====
// Bitmap to page-column transposer.
// pix_i takes one bitmap byte per transaction, row-major, MSB leftmost.
// col_o gives display bytes in page-column order, bit 0 the top row of the
// strip, with page and column address and begin/last/error marks.
// Configuration (width, height, start page, start column) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// Rows 0..6 of a strip live in a one-port-write, one-port-read memory, one
// 56-bit entry per byte column; a byte not on a strip's last row is written
// into its byte lane, no output; one byte a cycle while pix_i.ready is high.
// A strip-closing byte reads its entry into the read stage, is transposed,
// and the serializer then drives eight column bytes, one per cycle while
// col_o is ready. A new byte is taken while the previous eight drain, until
// one closing byte waits in the read stage; further input is then held off
// until the run ends. When col_o stalls, the serializer holds its byte.
// Reset clears counters, handshake state and the registers (width 16,
// height 64, page 0, column 0). The strip memory is not cleared.
`default_nettype none

module bitmap_to_page_column_transposer_core #(
  parameter int MAX_WIDTH_BYTES = 16,
  parameter int MAX_HEIGHT      = 64
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  bmptr_pix_if.sink                          pix_i,
  bmptr_col_if.source                        col_o,
  input  wire                                cfg_we_i,
  input  wire [bmptr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [bmptr_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int ColW   = (MAX_WIDTH_BYTES > 1) ? $clog2(MAX_WIDTH_BYTES) : 1;
  localparam int RowW   = $clog2(MAX_HEIGHT);
  localparam int WClog  = $clog2(MAX_WIDTH_BYTES + 1);
  localparam int HClog  = $clog2(MAX_HEIGHT + 1);
  localparam int WW     = (WClog > 5) ? WClog : 5;
  localparam int HW     = (HClog > 7) ? HClog : 7;
  localparam int StripW = (RowW > 3) ? RowW - 3 : 1;
  localparam int PsW    = ((StripW > 3) ? StripW : 3) + 1;
  localparam int EntW   = (bmptr_pkg::RowsPerStrip - 1) * bmptr_pkg::PixW;

  // configuration registers
  logic [4:0] width_q;
  logic [6:0] height_q;
  logic [2:0] spage_q;
  logic [6:0] scol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 5'd16;
      height_q <= 7'd64;
      spage_q  <= 3'd0;
      scol_q   <= 7'd0;
    end else if (cfg_we_i) begin
      unique case (bmptr_pkg::cfg_reg_e'(cfg_idx_i))
        bmptr_pkg::REG_WIDTH_BYTES:  width_q  <= cfg_data_i[4:0];
        bmptr_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        bmptr_pkg::REG_START_PAGE:   spage_q  <= cfg_data_i[2:0];
        bmptr_pkg::REG_START_COLUMN: scol_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    w_eff = WW'(width_q);
    if (w_eff == '0) w_eff = WW'(1);
    else if (w_eff > WW'(MAX_WIDTH_BYTES)) w_eff = WW'(MAX_WIDTH_BYTES);
    h_eff = HW'(height_q);
    if (h_eff == '0) h_eff = HW'(1);
    else if (h_eff > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
  end

  // position counters
  logic [ColW-1:0] col_q, col_d, col_cur;
  logic [RowW-1:0] row_q, row_d, row_cur;
  logic [2:0]      rin;
  logic            row_last, col_last, closing, accept;
  logic [StripW-1:0] strip;
  logic [PsW-1:0]  page_sum;

  always_comb begin
    col_cur  = (WW'(col_q) >= w_eff) ? '0 : col_q;
    row_cur  = (HW'(row_q) >= h_eff) ? '0 : row_q;
    rin      = row_cur[2:0];
    row_last = (HW'(row_cur) == h_eff - HW'(1));
    col_last = (WW'(col_cur) == w_eff - WW'(1));
    closing  = (rin == 3'd7) || row_last;
    strip    = StripW'({1'b0, row_cur} >> 3);
    page_sum = PsW'(spage_q) + PsW'(strip);
    if (col_last) begin
      col_d = '0;
      row_d = row_last ? '0 : row_cur + RowW'(1);
    end else begin
      col_d = col_cur + ColW'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // strip memory: rows 0..6 of each byte column
  logic [EntW-1:0] mem [MAX_WIDTH_BYTES];
  logic [EntW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && !closing) begin
      mem[col_cur][bmptr_pkg::PixW*rin +: bmptr_pkg::PixW] <= pix_i.pixel_byte;
    end
    if (accept && closing) begin
      rd_q <= mem[col_cur];
    end
  end

  // read stage and serializer handshake
  logic                    s1_valid_q, ser_valid_q, ser_free, s1_move;
  bmptr_pkg::strip_item_t  s1_q, ser_item_q;
  bmptr_pkg::col_bytes_t   ser_cols_q, cols;
  logic [2:0]              ser_k_q;
  logic [bmptr_pkg::RowsPerStrip-1:0][bmptr_pkg::PixW-1:0] rows;

  assign ser_free    = !ser_valid_q || (col_o.ready && ser_k_q == 3'd7);
  assign s1_move     = s1_valid_q && ser_free;
  assign pix_i.ready = !s1_valid_q || ser_free;
  assign accept      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept && closing) begin
      s1_q.pix     <= pix_i.pixel_byte;
      s1_q.rin     <= rin;
      s1_q.page    <= page_sum[bmptr_pkg::PageW-1:0];
      s1_q.perr    <= (page_sum > PsW'(bmptr_pkg::MaxPage));
      s1_q.base    <= bmptr_pkg::ColAddrW'({1'b0, scol_q})
                    + bmptr_pkg::ColAddrW'({col_cur, 3'b000});
      s1_q.first   <= (col_cur == '0);
      s1_q.img_end <= row_last && col_last;
    end
  end

  // transpose: column k holds pixel bit 7-k of every row
  always_comb begin
    for (int r = 0; r < bmptr_pkg::RowsPerStrip; r++) begin
      if (3'(r) < s1_q.rin) rows[r] = rd_q[bmptr_pkg::PixW*r +: bmptr_pkg::PixW];
      else if (3'(r) == s1_q.rin) rows[r] = s1_q.pix;
      else rows[r] = '0;
    end
    for (int k = 0; k < bmptr_pkg::RowsPerStrip; k++) begin
      for (int r = 0; r < bmptr_pkg::RowsPerStrip; r++) begin
        cols[k][r] = rows[r][bmptr_pkg::PixW-1-k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      ser_valid_q <= 1'b0;
      ser_k_q     <= 3'd0;
    end else begin
      if (accept && closing) s1_valid_q <= 1'b1;
      else if (s1_move)      s1_valid_q <= 1'b0;

      if (s1_move) begin
        ser_valid_q <= 1'b1;
        ser_k_q     <= 3'd0;
      end else if (ser_valid_q && col_o.ready) begin
        if (ser_k_q == 3'd7) ser_valid_q <= 1'b0;
        ser_k_q <= ser_k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      ser_cols_q <= cols;
      ser_item_q <= s1_q;
    end
  end

  assign col_o.valid       = ser_valid_q;
  assign col_o.column_byte = ser_cols_q[ser_k_q];
  assign col_o.page_addr   = ser_item_q.page;
  assign col_o.column_addr = ser_item_q.base + bmptr_pkg::ColAddrW'(ser_k_q);
  assign col_o.page_begin  = ser_item_q.first && (ser_k_q == 3'd0);
  assign col_o.run_last    = (ser_k_q == 3'd7);
  assign col_o.image_last  = ser_item_q.img_end && (ser_k_q == 3'd7);
  assign col_o.page_error  = ser_item_q.perr;

  // a closing transaction always lands in the read stage
  a_close_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && closing |=> s1_valid_q)
    else $error("closing transaction lost before read stage");

  // consecutive bytes of one run address consecutive columns
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_o.valid && col_o.ready && !col_o.run_last |=>
      col_o.valid && col_o.column_addr == $past(col_o.column_addr) + 8'd1)
    else $error("column address did not advance within a run");

  a_img_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_o.valid && col_o.image_last |-> col_o.run_last)
    else $error("image end outside the last byte of a run");

  // a finished run with a waiting strip starts the next run at once
  a_run_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_o.valid && col_o.ready && col_o.run_last && s1_valid_q |=>
      col_o.valid && ser_k_q == 3'd0)
    else $error("waiting strip not handed to serializer");

endmodule

`default_nettype wire
